### design/cht_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table package
// Shared widths, request and status codes, and the item type that passes from
// the front part to the back part.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 16;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 10;
  localparam int BC_W     = 7;
  localparam int SUM_W    = 14;
  localparam int REM_W    = 7;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [REM_W-1:0]    bucket;
  } cht_item_t;

endpackage

### design/cht_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/cht_front.sv
// ----------------------------------------------------------------------------
// Chained hash table front part
// Accepts a request, trims the key, forms the weighted character sum and
// reduces it modulo the bucket count two bits a cycle.
// ----------------------------------------------------------------------------
module cht_front
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = 64,
  parameter int KEY_CHARS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [BC_W-1:0]     bucket_count,
  input  logic                clearing,
  input  logic                push,
  output logic                full,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [KEY_W-1:0]    key,
  input  logic [HANDLE_W-1:0] handle,
  output logic                item_valid,
  input  logic                item_ready,
  output cht_item_t           item
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SUM  = 2'd1;
  localparam logic [1:0] F_MOD  = 2'd2;
  localparam logic [1:0] F_OUT  = 2'd3;

  logic [1:0]          state;
  logic [REQ_W-1:0]    req_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [SUM_W-1:0]    sum;
  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    mod_r;
  logic [2:0]          step;

  logic [KEY_W-1:0]    nkey;
  logic [REM_W-1:0]    mod_c;
  logic [SUM_W-1:0]    sum_c;
  logic [REM_W:0]      r1;
  logic [REM_W:0]      r2;

  always_comb begin
    logic alive;
    alive = 1'b1;
    nkey  = '0;
    for (int i = 0; i < 8; i++) begin
      alive = alive && (i < KEY_CHARS) && (key[8*i +: 8] != 8'd0);
      if (alive) begin
        nkey[8*i +: 8] = key[8*i +: 8];
      end
    end
  end

  always_comb begin
    if (bucket_count == '0) begin
      mod_c = REM_W'(1);
    end else if (32'(bucket_count) > MAX_BUCKETS) begin
      mod_c = REM_W'(MAX_BUCKETS);
    end else begin
      mod_c = bucket_count;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < 8; i++) begin
      sum_c = sum_c + SUM_W'(key_r[8*i +: 8]) * SUM_W'(i + 1);
    end
  end

  always_comb begin
    r1 = {rem, sum[SUM_W-1]};
    if (r1 >= {1'b0, mod_r}) begin
      r1 = r1 - {1'b0, mod_r};
    end
    r2 = {r1[REM_W-1:0], sum[SUM_W-2]};
    if (r2 >= {1'b0, mod_r}) begin
      r2 = r2 - {1'b0, mod_r};
    end
  end

  assign full       = (state != F_IDLE) || clearing;
  assign item_valid = (state == F_OUT);
  assign item.req    = req_r;
  assign item.key    = key_r;
  assign item.handle = handle_r;
  assign item.bucket = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (push && !full) begin
            state <= F_SUM;
          end
        end
        F_SUM: begin
          state <= F_MOD;
        end
        F_MOD: begin
          if (step == 3'(SUM_W / 2 - 1)) begin
            state <= F_OUT;
          end
        end
        F_OUT: begin
          if (item_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        req_r    <= req_type;
        key_r    <= nkey;
        handle_r <= handle;
        mod_r    <= mod_c;
      end
      F_SUM: begin
        sum  <= sum_c;
        rem  <= '0;
        step <= '0;
      end
      F_MOD: begin
        rem  <= r2[REM_W-1:0];
        sum  <= {sum[SUM_W-3:0], 2'b00};
        step <= step + 3'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

### design/cht_back.sv
// ----------------------------------------------------------------------------
// Chained hash table back part
// Scans one bucket of the entry memory, inserts, deletes with gap closing or
// looks up, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module cht_back
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = 64,
  parameter int CHAIN_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  output logic                clearing,
  input  logic                item_valid,
  input  cht_item_t           item,
  output logic                item_take,
  input  logic                pop,
  output logic                empty,
  output logic [STATUS_W-1:0] status,
  output logic [HANDLE_W-1:0] found_handle,
  output logic [COUNT_W-1:0]  record_count
);

  localparam int SLOTS = MAX_BUCKETS * CHAIN_DEPTH;
  localparam int BW    = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
  localparam int AW    = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int FW    = $clog2(CHAIN_DEPTH + 1);
  localparam int EW    = KEY_W + HANDLE_W;

  localparam logic [2:0] B_CLEAR  = 3'd0;
  localparam logic [2:0] B_IDLE   = 3'd1;
  localparam logic [2:0] B_FILL   = 3'd2;
  localparam logic [2:0] B_SCAN   = 3'd3;
  localparam logic [2:0] B_DECIDE = 3'd4;
  localparam logic [2:0] B_SHIFT  = 3'd5;
  localparam logic [2:0] B_FINISH = 3'd6;

  function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b, input logic [FW-1:0] s);
    return AW'(32'(b) * CHAIN_DEPTH + 32'(s));
  endfunction

  logic [2:0]          state;
  logic [BW-1:0]       clr_addr;
  logic [REQ_W-1:0]    req_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [BW-1:0]       bkt;
  logic [FW-1:0]       fill;
  logic [FW-1:0]       issue_i;
  logic                rd_pend;
  logic [FW-1:0]       rd_i;
  logic                found;
  logic [FW-1:0]       pos;
  logic [HANDLE_W-1:0] fhandle;
  logic [FW-1:0]       sj;
  logic                wr_pend;
  logic [FW-1:0]       wr_j;
  logic                out_valid;
  logic [STATUS_W-1:0] status_r;
  logic [HANDLE_W-1:0] found_r;
  logic [COUNT_W-1:0]  total;

  logic                kr_we;
  logic [AW-1:0]       kr_waddr;
  logic [EW-1:0]       kr_wdata;
  logic [AW-1:0]       kr_raddr;
  logic [EW-1:0]       kr_rdata;
  logic                fr_we;
  logic [BW-1:0]       fr_waddr;
  logic [FW-1:0]       fr_wdata;
  logic [BW-1:0]       fr_raddr;
  logic [FW-1:0]       fr_rdata;
  logic                ins_ok;

  cht_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entries (
    .clk   (clk),
    .we    (kr_we),
    .waddr (kr_waddr),
    .wdata (kr_wdata),
    .raddr (kr_raddr),
    .rdata (kr_rdata)
  );

  cht_ram #(.WIDTH(FW), .DEPTH(MAX_BUCKETS)) u_fill (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  assign clearing     = (state == B_CLEAR);
  assign item_take    = (state == B_IDLE) && item_valid && !out_valid;
  assign empty        = !out_valid;
  assign status       = status_r;
  assign found_handle = found_r;
  assign record_count = total;
  assign ins_ok       = (handle_r != '0) && !found && (32'(fill) < CHAIN_DEPTH);

  always_comb begin
    kr_we    = 1'b0;
    kr_waddr = slot_addr(bkt, fill);
    kr_wdata = {key_r, handle_r};
    kr_raddr = slot_addr(bkt, issue_i);
    fr_we    = 1'b0;
    fr_waddr = bkt;
    fr_wdata = '0;
    fr_raddr = BW'(32'(item.bucket));
    case (state)
      B_CLEAR: begin
        fr_we    = 1'b1;
        fr_waddr = clr_addr;
      end
      B_DECIDE: begin
        if (req_r == REQ_INSERT && ins_ok) begin
          kr_we    = 1'b1;
          fr_we    = 1'b1;
          fr_wdata = FW'(fill + 1'b1);
        end
      end
      B_SHIFT: begin
        kr_raddr = slot_addr(bkt, sj);
        kr_waddr = slot_addr(bkt, wr_j);
        kr_wdata = kr_rdata;
        kr_we    = wr_pend;
      end
      B_FINISH: begin
        fr_we    = 1'b1;
        fr_wdata = FW'(fill - 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      total     <= '0;
      rd_pend   <= 1'b0;
      wr_pend   <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BW'(MAX_BUCKETS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (item_take) begin
            state <= B_FILL;
          end
        end
        B_FILL: begin
          issue_i <= '0;
          rd_pend <= 1'b0;
          found   <= 1'b0;
          state   <= B_SCAN;
        end
        B_SCAN: begin
          if (rd_pend && kr_rdata[EW-1:HANDLE_W] == key_r) begin
            found   <= 1'b1;
            pos     <= rd_i;
            fhandle <= kr_rdata[HANDLE_W-1:0];
            rd_pend <= 1'b0;
            state   <= B_DECIDE;
          end else if (issue_i < fill) begin
            rd_pend <= 1'b1;
            rd_i    <= issue_i;
            issue_i <= issue_i + 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= B_DECIDE;
            end
          end
        end
        B_DECIDE: begin
          state <= B_IDLE;
          case (req_r)
            REQ_INSERT: begin
              out_valid <= 1'b1;
              found_r   <= '0;
              if (handle_r == '0) begin
                status_r <= ST_NULL;
              end else if (found) begin
                status_r <= ST_DUP;
              end else if (!ins_ok) begin
                status_r <= ST_FULL;
              end else begin
                status_r <= ST_OK;
                total    <= total + 1'b1;
              end
            end
            REQ_DELETE: begin
              if (!found) begin
                out_valid <= 1'b1;
                status_r  <= ST_NOT_FOUND;
                found_r   <= '0;
              end else begin
                sj      <= FW'(pos + 1'b1);
                wr_pend <= 1'b0;
                state   <= B_SHIFT;
              end
            end
            REQ_LOOKUP: begin
              out_valid <= 1'b1;
              status_r  <= found ? ST_OK : ST_NOT_FOUND;
              found_r   <= found ? fhandle : '0;
            end
            default: begin
              out_valid <= 1'b1;
              status_r  <= ST_OK;
              found_r   <= '0;
            end
          endcase
        end
        B_SHIFT: begin
          if (sj < fill) begin
            wr_pend <= 1'b1;
            wr_j    <= FW'(sj - 1'b1);
            sj      <= sj + 1'b1;
          end else if (wr_pend) begin
            wr_pend <= 1'b0;
          end else begin
            state <= B_FINISH;
          end
        end
        B_FINISH: begin
          out_valid <= 1'b1;
          status_r  <= ST_OK;
          found_r   <= '0;
          if (total != '0) begin
            total <= total - 1'b1;
          end
          state <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && item_take) begin
      req_r    <= item.req;
      key_r    <= item.key;
      handle_r <= item.handle;
      bkt      <= BW'(32'(item.bucket));
    end
    if (state == B_FILL) begin
      fill <= fr_rdata;
    end
  end

`ifndef SYNTHESIS
  a_clear_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !out_valid)
    else $error("result present during the clearing pass");
  a_take_reads_fill: assert property (@(posedge clk) disable iff (rst)
    item_take |=> (state == B_FILL))
    else $error("taken item did not start a bucket read");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= SLOTS)
    else $error("record count exceeds the store size");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == B_DECIDE || $past(state) == B_FINISH))
    else $error("result raised outside a completing state");
`endif

endmodule

### design/chained_hash_table_engine_core.sv
// ----------------------------------------------------------------------------
// Chained hash table engine
// Keyed store with separate chaining: insert, delete and lookup of packed
// keys, with a front part for hashing and a back part for bucket work.
//
// Channel   Direction  Handshake            Beat
// request   in         push / full          req_type, key, handle
// result    out        empty / pop          status, found_handle, record_count
// config    in         cfg_valid/cfg_ready  cfg_data (bucket_count)
//
// The front part works on one request at a time: a sum step, then the
// two-bit-per-cycle modulo, set by the remainder loop, then the output.
// The back part reads the fill count, scans the bucket entry by entry and,
// on a delete, moves each later entry down, through the single entry memory.
// After reset a clearing pass writes every one of the MAX_BUCKETS fill table
// entries to zero, with full held high. A two-beat queue parts the two parts.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_core
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = 64,
  parameter int CHAIN_DEPTH = 8,
  parameter int KEY_CHARS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [KEY_W-1:0]    key,
  input  logic [HANDLE_W-1:0] handle,
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] status,
  output logic [HANDLE_W-1:0] found_handle,
  output logic [COUNT_W-1:0]  record_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BC_W-1:0]     cfg_data
);

  logic [BC_W-1:0] bucket_count;
  logic            clearing;
  logic            f_valid;
  logic            f_ready;
  cht_item_t       f_item;
  cht_item_t       q_item [2];
  logic            wp;
  logic            rp;
  logic [1:0]      cnt;
  logic            b_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BC_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      bucket_count <= cfg_data;
    end
  end

  cht_front #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_CHARS(KEY_CHARS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .bucket_count (bucket_count),
    .clearing     (clearing),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .key          (key),
    .handle       (handle),
    .item_valid   (f_valid),
    .item_ready   (f_ready),
    .item         (f_item)
  );

  assign f_ready = (cnt != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (f_valid && f_ready) begin
        wp <= !wp;
      end
      if (b_take) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(f_valid && f_ready) - 2'(b_take);
    end
  end

  always_ff @(posedge clk) begin
    if (f_valid && f_ready) begin
      q_item[wp] <= f_item;
    end
  end

  cht_back #(.MAX_BUCKETS(MAX_BUCKETS), .CHAIN_DEPTH(CHAIN_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .item_valid   (cnt != 2'd0),
    .item         (q_item[rp]),
    .item_take    (b_take),
    .pop          (pop),
    .empty        (empty),
    .status       (status),
    .found_handle (found_handle),
    .record_count (record_count)
  );

endmodule
